// ===== rtl/mf3_pkg.sv =====
package mf3_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int PIX_W        = 8;
  localparam int IMG_WIDTH_W  = 11;
  localparam int IMG_HEIGHT_W = 16;
  localparam int WIN_N        = 9;

  localparam logic [IMG_WIDTH_W-1:0]  WIDTH_RESET  = IMG_WIDTH_W'(1024);
  localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_RESET = IMG_HEIGHT_W'(768);

  // register index, paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             first_of_frame;
  } pixel_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic             last_of_frame;
  } median_rsp_t;

  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

  function automatic win_t cmp_swap(win_t v, int a, int b);
    win_t r;
    r = v;
    if (v[a] > v[b]) begin
      r[a] = v[b];
      r[b] = v[a];
    end
    return r;
  endfunction

  // sort each group of three
  function automatic win_t sort_rows(win_t v);
    win_t r;
    r = v;
    r = cmp_swap(r, 1, 2); r = cmp_swap(r, 4, 5); r = cmp_swap(r, 7, 8);
    r = cmp_swap(r, 0, 1); r = cmp_swap(r, 3, 4); r = cmp_swap(r, 6, 7);
    r = cmp_swap(r, 1, 2); r = cmp_swap(r, 4, 5); r = cmp_swap(r, 7, 8);
    return r;
  endfunction

  function automatic win_t merge_a(win_t v);
    win_t r;
    r = v;
    r = cmp_swap(r, 0, 3); r = cmp_swap(r, 5, 8); r = cmp_swap(r, 4, 7);
    r = cmp_swap(r, 3, 6); r = cmp_swap(r, 1, 4); r = cmp_swap(r, 2, 5);
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] merge_b(win_t v);
    win_t r;
    r = v;
    r = cmp_swap(r, 4, 7); r = cmp_swap(r, 4, 2); r = cmp_swap(r, 6, 4);
    r = cmp_swap(r, 4, 2);
    return r[4];
  endfunction

endpackage

// ===== rtl/median_filter_3x3_core.sv =====
// Channel | Dir | Signals                         | Request
// pixel   | in  | px_valid, px_stall, px_data     | one raster pixel + frame start
// median  | out | med_valid, med_stall, med_data  | median of one interior 3x3 window
// config  | in  | psel/penable/pwrite/paddr/pwdata| image_width @0x0, image_height @0x4
//
// One pixel per cycle, sustained while no result is stalled; the line buffers take one read
// and one write per cycle. Result register loads after the memory read at accept, then
// three sort stages; the median can be taken at the following edge.
// Reset clears counters, window and pipeline; line buffers are not cleared and hold
// valid data once two rows have passed.
// A stalled result holds only the stages behind it; empty stages keep taking pixels.
module median_filter_3x3_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     px_valid,
  output logic                     px_stall,
  input  mf3_pkg::pixel_req_t      px_data,
  output logic                     med_valid,
  input  logic                     med_stall,
  output mf3_pkg::median_rsp_t     med_data,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import mf3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = IMG_HEIGHT_W;

  // configuration
  logic [IMG_WIDTH_W-1:0]  image_width;
  logic [IMG_HEIGHT_W-1:0] image_height;
  logic                    cfg_write;
  logic                    reg_sel;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_WIDTH:  image_width  <= pwdata[IMG_WIDTH_W-1:0];
        REG_HEIGHT: image_height <= pwdata[IMG_HEIGHT_W-1:0];
        default:    image_width  <= image_width;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      default:    prdata = '0;
    endcase
  end

  logic [COL_W:0] width_eff;

  always_comb begin
    if (int'(image_width) > MAX_WIDTH) begin
      width_eff = (COL_W+1)'(MAX_WIDTH);
    end else if (image_width == '0) begin
      width_eff = (COL_W+1)'(1);
    end else begin
      width_eff = (COL_W+1)'(image_width);
    end
  end

  // pipeline control
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_emit, s1_leave;
  logic rdy1, rdy2, rdy3, rdy4;
  logic accept;

  assign rdy4     = !s4_valid || !med_stall;
  assign rdy3     = !s3_valid || rdy4;
  assign rdy2     = !s2_valid || rdy3;
  assign s1_leave = s1_valid && (!s1_emit || rdy2);
  assign rdy1     = !s1_valid || s1_leave;
  assign px_stall = !rdy1;
  assign accept   = px_valid && rdy1;

  // position counters
  logic [COL_W-1:0] col, col_a, col_next;
  logic [ROW_W-1:0] row, row_a, row_next;
  logic [COL_W:0]   col_inc;
  logic             wrap, emit_a, last_a;

  always_comb begin
    col_a = px_data.first_of_frame ? '0 : col;
    row_a = px_data.first_of_frame ? '0 : row;
    if ({1'b0, col_a} >= width_eff) begin
      col_a = '0;
    end
    emit_a  = (row_a >= ROW_W'(2)) && (col_a >= COL_W'(2));
    last_a  = (({1'b0, row_a} + (ROW_W+1)'(1)) == {1'b0, image_height})
              && (({1'b0, col_a} + (COL_W+1)'(1)) == width_eff);
    col_inc = {1'b0, col_a} + (COL_W+1)'(1);
    wrap    = col_inc >= width_eff;
    if (wrap) begin
      col_next = '0;
      row_next = (row_a == '1) ? row_a : row_a + ROW_W'(1);
    end else begin
      col_next = col_inc[COL_W-1:0];
      row_next = row_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // line buffers
  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] upper_rd, middle_rd;
  logic [PIX_W-1:0] top_eff, mid_eff;

  logic [COL_W-1:0] s1_col;
  logic [PIX_W-1:0] s1_pixel, s1_fwd_top, s1_fwd_mid;
  logic             s1_last, s1_fwd;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      upper_mem[s1_col] <= mid_eff;
    end
    if (accept) begin
      upper_rd <= upper_mem[col_a];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      middle_mem[s1_col] <= s1_pixel;
    end
    if (accept) begin
      middle_rd <= middle_mem[col_a];
    end
  end

  // same column back to back: take the values still being written
  assign top_eff = s1_fwd ? s1_fwd_top : upper_rd;
  assign mid_eff = s1_fwd ? s1_fwd_mid : middle_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= px_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col     <= col_a;
      s1_pixel   <= px_data.pixel;
      s1_emit    <= emit_a;
      s1_last    <= last_a;
      s1_fwd     <= s1_valid && (s1_col == col_a);
      s1_fwd_top <= mid_eff;
      s1_fwd_mid <= s1_pixel;
    end
  end

  // window: [0..2] oldest column, [3..5] middle column
  logic [5:0][PIX_W-1:0] win;
  win_t                  v1;

  always_comb begin
    v1[5:0] = win;
    v1[6]   = top_eff;
    v1[7]   = mid_eff;
    v1[8]   = s1_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_leave) begin
      win[2:0] <= win[5:3];
      win[3]   <= top_eff;
      win[4]   <= mid_eff;
      win[5]   <= s1_pixel;
    end
  end

  // median network stages
  win_t             s2_v, s3_v;
  logic             s2_last, s3_last, s4_last;
  logic [PIX_W-1:0] s4_median;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (rdy2) s2_valid <= s1_valid && s1_emit;
      if (rdy3) s3_valid <= s2_valid;
      if (rdy4) s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_v    <= sort_rows(v1);
      s2_last <= s1_last;
    end
    if (rdy3) begin
      s3_v    <= merge_a(s2_v);
      s3_last <= s2_last;
    end
    if (rdy4) begin
      s4_median <= merge_b(s3_v);
      s4_last   <= s3_last;
    end
  end

  assign med_valid              = s4_valid;
  assign med_data.median        = s4_median;
  assign med_data.last_of_frame = s4_last;

endmodule

// ===== rtl/mf3_checker.sv =====
module mf3_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 px_valid,
  input logic                 px_stall,
  input mf3_pkg::pixel_req_t  px_data,
  input logic                 med_valid,
  input logic                 med_stall,
  input mf3_pkg::median_rsp_t med_data
);
  import mf3_pkg::*;

  logic px_acc;
  assign px_acc = px_valid && !px_stall;

  a_reset_empty: assert property (@(posedge clk) rst |=> !med_valid)
    else $error("result valid right after reset");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !med_valid |-> !px_stall)
    else $error("pixel stalled with empty result register");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!px_acc && !med_stall) ##1 (!px_acc && !med_stall) ##1
    (!px_acc && !med_stall) ##1 (!px_acc && !med_stall) |=> !med_valid)
    else $error("pipeline did not drain");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    med_valid && med_stall |=> med_valid && $stable(med_data))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    px_valid && px_stall |=> px_valid && $stable(px_data))
    else $error("stalled request changed");

endmodule

bind median_filter_3x3_core mf3_checker u_mf3_checker (
  .clk       (clk),
  .rst       (rst),
  .px_valid  (px_valid),
  .px_stall  (px_stall),
  .px_data   (px_data),
  .med_valid (med_valid),
  .med_stall (med_stall),
  .med_data  (med_data)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import mf3_pkg::*;

  localparam logic [2:0]  ADDR_WIDTH     = {REG_WIDTH, 2'b00};
  localparam logic [2:0]  ADDR_HEIGHT    = {REG_HEIGHT, 2'b00};
  localparam int          SETTLE_CYCLES  = 10;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WIDE_COLS      = 48;
  localparam int          REPORT_MAX     = 10;
  localparam int unsigned NO_LIMIT       = 32'hFFFF_FFFF;

  logic        clk;
  logic        rst;
  logic        px_valid;
  logic        px_stall;
  pixel_req_t  px_data;
  logic        med_valid;
  logic        med_stall;
  median_rsp_t med_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the filter state
  logic [PIX_W-1:0]        line_up  [MAX_WIDTH];
  logic [PIX_W-1:0]        line_mid [MAX_WIDTH];
  logic [5:0][PIX_W-1:0]   win_cols;
  int unsigned             col_pos;
  int unsigned             row_pos;
  logic [IMG_WIDTH_W-1:0]  cfg_width;
  logic [IMG_HEIGHT_W-1:0] cfg_height;
  median_rsp_t             pending_medians[$];

  bit          tx_gaps;
  bit          rx_gaps;
  int unsigned long_hold;
  int unsigned n_pixels;
  int unsigned n_medians;
  int unsigned n_frame_ends;
  int unsigned n_mismatch;
  int unsigned n_geometries;
  int unsigned quiet_cycles;

  median_filter_3x3_core uut (
    .clk       (clk),
    .rst       (rst),
    .px_valid  (px_valid),
    .px_stall  (px_stall),
    .px_data   (px_data),
    .med_valid (med_valid),
    .med_stall (med_stall),
    .med_data  (med_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_error(input string msg);
    n_mismatch++;
    if (n_mismatch <= REPORT_MAX) $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic filter_pixel(input pixel_req_t req);
    int unsigned          eff_w;
    int                   i;
    int                   j;
    logic [PIX_W-1:0]     top_px;
    logic [PIX_W-1:0]     mid_px;
    logic [PIX_W-1:0]     t;
    logic [8:0][PIX_W-1:0] nb;
    median_rsp_t          r;
    if (cfg_width > MAX_WIDTH) eff_w = MAX_WIDTH;
    else if (cfg_width == 0) eff_w = 1;
    else eff_w = cfg_width;
    if (req.first_of_frame) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= eff_w) col_pos = 0;
    top_px = line_up[col_pos];
    mid_px = line_mid[col_pos];
    line_up[col_pos]  = mid_px;
    line_mid[col_pos] = req.pixel;
    if (row_pos >= 2 && col_pos >= 2) begin
      for (i = 0; i < 6; i++) nb[i] = win_cols[i];
      nb[6] = top_px;
      nb[7] = mid_px;
      nb[8] = req.pixel;
      for (i = 1; i < 9; i++) begin
        for (j = i; j > 0; j--) begin
          if (nb[j-1] > nb[j]) begin
            t       = nb[j];
            nb[j]   = nb[j-1];
            nb[j-1] = t;
          end
        end
      end
      r.median        = nb[4];
      r.last_of_frame = (row_pos + 1 == cfg_height) && (col_pos + 1 == eff_w);
      pending_medians.push_back(r);
    end
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = top_px;
    win_cols[4] = mid_px;
    win_cols[5] = req.pixel;
    if (col_pos + 1 >= eff_w) begin
      col_pos = 0;
      if (row_pos < 65535) row_pos++;
    end else begin
      col_pos++;
    end
    n_pixels++;
  endtask

  // entered and left at a falling edge
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit sof);
    pixel_req_t  req;
    int unsigned gap;
    req.pixel          = pix;
    req.first_of_frame = sof;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      px_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    px_valid <= 1'b1;
    px_data  <= req;
    @(posedge clk);
    while (px_stall) @(posedge clk);
    filter_pixel(req);
    @(negedge clk);
  endtask

  task automatic send_frame(input int unsigned cols, input int unsigned rows,
                            input int unsigned stop_after, input bit noisy);
    int unsigned      total;
    int unsigned      k;
    logic [PIX_W-1:0] pix;
    bit               sof;
    total = cols * rows;
    for (k = 0; k < total && k < stop_after; k++) begin
      case ($urandom_range(0, 7))
        0: pix = '0;
        1: pix = '1;
        2: pix = 8'(120 + $urandom_range(0, 15));
        default: pix = 8'($urandom());
      endcase
      sof = (k == 0) || (noisy && $urandom_range(0, 59) == 0);
      send_pixel(pix, sof);
    end
  endtask

  task automatic drain_results();
    px_valid <= 1'b0;
    do @(negedge clk); while (pending_medians.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_access(input logic [2:0] addr, input bit wr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    logic [31:0] rd;
    drain_results();
    reg_access(ADDR_WIDTH, 1'b1, ($urandom() & 32'hFFFF_F800) | (w & 32'h7FF), rd);
    cfg_width = IMG_WIDTH_W'(w);
    reg_access(ADDR_HEIGHT, 1'b1, ($urandom() & 32'hFFFF_0000) | (h & 32'hFFFF), rd);
    cfg_height = IMG_HEIGHT_W'(h);
    reg_access(ADDR_WIDTH, 1'b0, '0, rd);
    if (rd !== 32'(cfg_width))
      flag_error($sformatf("width readback exp %0d got %0h", cfg_width, rd));
    reg_access(ADDR_HEIGHT, 1'b0, '0, rd);
    if (rd !== 32'(cfg_height))
      flag_error($sformatf("height readback exp %0d got %0h", cfg_height, rd));
    n_geometries++;
  endtask

  task automatic test_register_reset();
    logic [31:0] rd;
    reg_access(ADDR_WIDTH, 1'b0, '0, rd);
    if (rd !== 32'(WIDTH_RESET))
      flag_error($sformatf("reset width exp %0d got %0h", WIDTH_RESET, rd));
    reg_access(ADDR_HEIGHT, 1'b0, '0, rd);
    if (rd !== 32'(HEIGHT_RESET))
      flag_error($sformatf("reset height exp %0d got %0h", HEIGHT_RESET, rd));
  endtask

  // all-white frame, a frame cut short, then a restart with a 0/255 checkerboard
  task automatic test_directed_windows();
    int unsigned k;
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    set_geometry(3, 3);
    for (k = 0; k < 9; k++) send_pixel(8'hFF, k == 0);
    for (k = 0; k < 4; k++) send_pixel(8'h00, k == 0);
    for (k = 0; k < 9; k++) send_pixel((k % 2) ? 8'hFF : 8'h00, k == 0);
  endtask

  task automatic test_width_extremes();
    int unsigned w;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    for (w = 0; w < 3; w++) begin
      set_geometry(w, 5);
      send_frame((w == 0) ? 1 : w, 10, NO_LIMIT, 1'b1);
    end
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    set_geometry(WIDE_COLS, 3);
    send_frame(WIDE_COLS, 3, NO_LIMIT, 1'b0);
  endtask

  task automatic test_height_extremes();
    int unsigned h;
    tx_gaps = 1'b1;
    rx_gaps = 1'b0;
    for (h = 0; h < 4; h++) begin
      set_geometry(4 + h, h);
      send_frame(4 + h, 5, NO_LIMIT, 1'b0);
    end
  endtask

  task automatic test_random_frames();
    int unsigned phase;
    int unsigned cols;
    int unsigned rows;
    int unsigned budget;
    int unsigned total;
    for (phase = 0; phase < 8; phase++) begin
      cols = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16) : $urandom_range(3, 6);
      rows = $urandom_range(3, 4);
      set_geometry(cols, rows);
      tx_gaps = (phase & 1) != 0;
      rx_gaps = (phase & 2) != 0;
      budget  = (cols * rows > 16) ? cols * rows : 16;
      while (budget > 0) begin
        total = cols * rows;
        if ($urandom_range(0, 7) == 0) total = $urandom_range(1, total);
        if (total > budget) total = budget;
        send_frame(cols, rows, total, $urandom_range(0, 3) == 0);
        budget -= total;
      end
    end
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    set_geometry(8, 10);
    long_hold = LONG_HOLD;
    send_frame(8, 10, NO_LIMIT, 1'b0);
    drain_results();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    send_frame(8, 10, NO_LIMIT, 1'b1);
  endtask

  initial begin : receiver
    int unsigned stall_left;
    med_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold != 0) begin
        med_stall <= 1'b1;
        repeat (long_hold) @(negedge clk);
        long_hold = 0;
        med_stall <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
      end else begin
        stall_left = rx_gaps ? pick_gap() : 0;
        med_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin : result_check
    median_rsp_t want;
    if (!rst && med_valid && !med_stall) begin
      if (pending_medians.size() == 0) begin
        flag_error($sformatf("unexpected median %0d last %0b",
                             med_data.median, med_data.last_of_frame));
      end else begin
        want = pending_medians.pop_front();
        n_medians++;
        if (want.last_of_frame) n_frame_ends++;
        if (med_data.median !== want.median)
          flag_error($sformatf("median #%0d exp %0d got %0d",
                               n_medians, want.median, med_data.median));
        if (med_data.last_of_frame !== want.last_of_frame)
          flag_error($sformatf("last_of_frame #%0d exp %0b got %0b",
                               n_medians, want.last_of_frame, med_data.last_of_frame));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((px_valid && !px_stall) || (med_valid && !med_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t timeout: no transfer for %0d cycles, %0d medians outstanding",
                 $time, quiet_cycles, pending_medians.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin : main
    rst          = 1'b1;
    px_valid     = 1'b0;
    px_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    tx_gaps      = 1'b0;
    rx_gaps      = 1'b0;
    long_hold    = 0;
    win_cols     = '0;
    col_pos      = 0;
    row_pos      = 0;
    cfg_width    = WIDTH_RESET;
    cfg_height   = HEIGHT_RESET;
    n_pixels     = 0;
    n_medians    = 0;
    n_frame_ends = 0;
    n_mismatch   = 0;
    n_geometries = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_register_reset();
    test_directed_windows();
    test_width_extremes();
    test_height_extremes();
    test_random_frames();
    test_backpressure();
    drain_results();

    $display("Covered %0d pixels over %0d geometries (widths 0 to 48, heights 0 to 10),",
             n_pixels, n_geometries);
    $display("frame restarts, long output back-pressure;");
    $display("%0d medians, %0d frame ends, %0d errors.",
             n_medians, n_frame_ends, n_mismatch);
    if (n_mismatch == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mf3_pkg.sv
rtl/median_filter_3x3_core.sv
rtl/mf3_checker.sv
verif/tb_top.sv
